// ===== hdl/u8dh_pkg.sv =====
// Shared types, status codes and lead-byte decoding for the UTF-8 decoder.
// Used by u8dh_decode, u8dh_result_fifo and utf8_decoder_with_hash.
`timescale 1ns / 1ps

package u8dh_pkg;

    // Result status codes.
    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_LEAD = 2'd1;
    localparam logic [1:0] ST_BROKEN   = 2'd2;

    // Byte class tags.
    localparam logic [1:0] CONT_TAG    = 2'b10;
    localparam logic [4:0] BAD_LEAD_TAG = 5'b11111;

    // Result queue geometry.
    localparam int QDEPTH = 4;
    localparam int QPTR_W = 2;
    localparam int QCNT_W = 3;

    // One result item.
    typedef struct packed {
        logic [20:0] code_point;
        logic [2:0]  char_length;
        logic [31:0] char_hash;
        logic [1:0]  status;
        logic        last_of_run;
    } result_t;

    // Decoder state carried between bytes.
    typedef struct packed {
        logic [1:0]  pending;
        logic [20:0] partial;
        logic [2:0]  seen;
        logic [31:0] hash;
    } dec_state_t;

    // Outcome of taking a byte as a lead while idle.
    typedef struct packed {
        logic       emit;
        result_t    res;
        dec_state_t st;
    } lead_t;

    // Decode one byte as the lead of a new character.
    function automatic lead_t decode_lead(input logic [7:0] b);
        lead_t l;
        l = '0;
        if (!b[7]) begin
            // Single-byte character.
            l.emit            = 1'b1;
            l.res.code_point  = {13'd0, b};
            l.res.char_length = 3'd1;
            l.res.char_hash   = {24'd0, b};
            l.res.status      = ST_OK;
        end else if (b[7:6] == CONT_TAG || b[7:3] == BAD_LEAD_TAG) begin
            l.emit       = 1'b1;
            l.res.status = ST_BAD_LEAD;
        end else begin
            // Multi-byte lead opens a character.
            l.st.seen = 3'd1;
            l.st.hash = {24'd0, b};
            priority if (!b[5]) begin
                l.st.pending = 2'd1;
                l.st.partial = {16'd0, b[4:0]};
            end else if (!b[4]) begin
                l.st.pending = 2'd2;
                l.st.partial = {17'd0, b[3:0]};
            end else begin
                l.st.pending = 2'd3;
                l.st.partial = {18'd0, b[2:0]};
            end
        end
        return l;
    endfunction

endpackage

// ===== hdl/u8dh_decode.sv =====
// Byte decoder: holds the per-character state and forms up to two results per byte.
// Depends on u8dh_pkg.
`timescale 1ns / 1ps

module u8dh_decode
    import u8dh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        take,
    input  logic [7:0]  in_byte,
    output logic [1:0]  push_count,
    output result_t     res0,
    output result_t     res1
);

    dec_state_t state_reg;
    dec_state_t state_next;
    lead_t      lead;
    dec_state_t cont_st;

    // Lead decode is needed both when idle and after a broken sequence.
    assign lead = decode_lead(in_byte);

    // Continuation update of the running value and hash (h*31 + byte).
    always_comb
    begin
        cont_st.partial = {state_reg.partial[14:0], in_byte[5:0]};
        cont_st.hash    = (state_reg.hash << 5) - state_reg.hash + {24'd0, in_byte};
        cont_st.seen    = state_reg.seen + 3'd1;
        cont_st.pending = state_reg.pending - 2'd1;
    end

    // Result formation and next state.
    always_comb
    begin
        res0       = '0;
        res1       = '0;
        push_count = 2'd0;
        state_next = state_reg;
        if (state_reg.pending == 2'd0) begin
            res0             = lead.res;
            res0.last_of_run = 1'b1;
            push_count       = {1'b0, lead.emit};
            state_next       = lead.st;
        end else if (in_byte[7:6] == CONT_TAG) begin
            if (cont_st.pending == 2'd0) begin
                res0.code_point  = cont_st.partial;
                res0.char_length = cont_st.seen;
                res0.char_hash   = cont_st.hash;
                res0.status      = ST_OK;
                res0.last_of_run = 1'b1;
                push_count       = 2'd1;
                state_next       = '0;
            end else begin
                state_next = cont_st;
            end
        end else begin
            // Broken sequence, then the byte is taken as a new lead.
            res0.status      = ST_BROKEN;
            res0.last_of_run = !lead.emit;
            res1             = lead.res;
            res1.last_of_run = 1'b1;
            push_count       = lead.emit ? 2'd2 : 2'd1;
            state_next       = lead.st;
        end
    end

    // State register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end else if (take) begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hdl/u8dh_result_fifo.sv =====
// Small result queue: takes up to two result items per cycle, gives one per cycle while out_stall is low.
// Depends on u8dh_pkg.
`timescale 1ns / 1ps

module u8dh_result_fifo
    import u8dh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [1:0]  push_count,
    input  result_t     push0,
    input  result_t     push1,
    output logic        almost_full,
    output logic        out_valid,
    input  logic        out_stall,
    output result_t     head
);

    result_t           entry_reg [QDEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_plus1;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              pop;

    assign out_valid    = (count_reg != '0);
    assign head         = entry_reg[rd_ptr_reg];
    assign pop          = out_valid && !out_stall;
    // Room for two more items is kept whenever input is allowed.
    assign almost_full  = (count_reg > QCNT_W'(QDEPTH - 2));
    assign wr_ptr_plus1 = wr_ptr_reg + 1'b1;
    assign wr_ptr_next  = wr_ptr_reg + push_count[QPTR_W-1:0];
    assign count_next   = count_reg + QCNT_W'(push_count) - QCNT_W'(pop);

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push_count != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push0;
        end
        if (push_count == 2'd2) begin
            entry_reg[wr_ptr_plus1] <= push1;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            count_reg  <= count_next;
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

// ===== hdl/utf8_decoder_with_hash.sv =====
// Top level of the UTF-8 decoder with per-character hash.
// Depends on u8dh_pkg, u8dh_decode and u8dh_result_fifo.
//
//   Channel | Handshake            | Payload
//   input   | in_valid / in_stall  | in_byte
//   output  | out_valid / out_stall| code_point, char_length, char_hash, status, last_of_run
//
// One byte is accepted per cycle while in_stall is low; its results enter a four-entry
// queue at the same edge and can leave from the next cycle on, one result item per
// cycle while out_stall is low. A byte that breaks a sequence and is a one-byte or bad
// lead gives two results, so a run of such bytes is limited by the single queue read port.
// in_stall rises when the queue holds three or more items; it depends on registers only.
// Reset clears the decoder state and empties the queue.
`timescale 1ns / 1ps

module utf8_decoder_with_hash
    import u8dh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [20:0] code_point,
    output logic [2:0]  char_length,
    output logic [31:0] char_hash,
    output logic [1:0]  status,
    output logic        last_of_run
);

    logic       take;
    logic       almost_full;
    logic [1:0] dec_count;
    logic [1:0] push_count;
    result_t    res0;
    result_t    res1;
    result_t    head;

    assign in_stall   = almost_full;
    assign take       = in_valid && !almost_full;
    assign push_count = take ? dec_count : 2'd0;

    // Byte decoder.
    u8dh_decode u_decode (
        .clk        (clk),
        .rst_n      (rst_n),
        .take       (take),
        .in_byte    (in_byte),
        .push_count (dec_count),
        .res0       (res0),
        .res1       (res1)
    );

    // Result queue.
    u8dh_result_fifo u_fifo (
        .clk         (clk),
        .rst_n       (rst_n),
        .push_count  (push_count),
        .push0       (res0),
        .push1       (res1),
        .almost_full (almost_full),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .head        (head)
    );

    // Output fields.
    assign code_point  = head.code_point;
    assign char_length = head.char_length;
    assign char_hash   = head.char_hash;
    assign status      = head.status;
    assign last_of_run = head.last_of_run;

endmodule
